>>> rtl/core/cdas_pkg.sv
// ----------------------------------------------------------------------------
// cdas_pkg
// Shared types, constants and calendar helpers for the date add/subtract unit.
// ----------------------------------------------------------------------------
package cdas_pkg;

    // field widths
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned COUNT_W = 12;
    localparam int unsigned REQ_W   = 2;
    localparam int unsigned CMP_W   = 2;

    // calendar limits
    localparam int unsigned MAX_YEAR      = 9999;
    localparam int unsigned MAX_STEP_DAYS = 4095;

    // year limit at field width, day count cap at field width
    localparam logic [YEAR_W-1:0]  YEAR_LIMIT = YEAR_W'(MAX_YEAR);
    localparam logic [COUNT_W-1:0] COUNT_CAP  =
        (MAX_STEP_DAYS > ((1 << COUNT_W) - 1)) ? {COUNT_W{1'b1}} : COUNT_W'(MAX_STEP_DAYS);

    // reset date
    localparam logic [DAY_W-1:0]   RST_DAY   = DAY_W'(1);
    localparam logic [MONTH_W-1:0] RST_MONTH = MONTH_W'(1);
    localparam logic [YEAR_W-1:0]  RST_YEAR  = YEAR_W'(1970);

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SUB  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CMP  = 2'd3;

    // compare result codes
    localparam logic [CMP_W-1:0] CMP_EQUAL   = 2'd0;
    localparam logic [CMP_W-1:0] CMP_LATER   = 2'd1;
    localparam logic [CMP_W-1:0] CMP_EARLIER = 2'd2;

    // months by number
    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    // month lengths
    localparam logic [DAY_W-1:0] LEN_LEAP_FEB = 5'd29;
    localparam logic [DAY_W-1:0] LEN_FEB      = 5'd28;
    localparam logic [DAY_W-1:0] LEN_SHORT    = 5'd30;
    localparam logic [DAY_W-1:0] LEN_LONG     = 5'd31;

    // result of one month step of the shared unit
    typedef struct packed {
        logic                 done;   // remaining days fit in this month
        logic                 wrap;   // step crosses a year boundary
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [COUNT_W-1:0]   count;
    } t_step_res;

    // days in a month, given the leap flag of its year
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        if (month == MON_FEB) begin
            len = leap ? LEN_LEAP_FEB : LEN_FEB;
        end else if (month == MON_APR || month == MON_JUN ||
                     month == MON_SEP || month == MON_NOV) begin
            len = LEN_SHORT;
        end else begin
            len = LEN_LONG;
        end
        return len;
    endfunction

endpackage

>>> rtl/core/cdas_leap.sv
// ----------------------------------------------------------------------------
// cdas_leap
// Leap year test: registered year / 100 by reciprocal, then the
// divisible-by-4 / 100 / 400 rule on the held quotient.
// ----------------------------------------------------------------------------
module cdas_leap (
    input  logic                      i_clk,
    input  logic [cdas_pkg::YEAR_W-1:0] i_year,  // must hold for two cycles
    output logic                      o_leap
);

    localparam int unsigned RECIP   = 5243;      // ceil(2^19 / 100)
    localparam int unsigned SHIFT   = 19;
    localparam int unsigned PROD_W  = cdas_pkg::YEAR_W + 13;
    localparam int unsigned QUOT_W  = 8;

    logic [PROD_W-1:0]               w_prod;
    logic [QUOT_W-1:0]               r_quot;
    logic [cdas_pkg::YEAR_W-1:0]     w_hundreds;
    logic                            w_div4;
    logic                            w_div100;

    // quotient by 100, exact for all 14-bit years
    assign w_prod = PROD_W'(i_year) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        r_quot <= w_prod[SHIFT +: QUOT_W];
    end

    // quotient times 100 from shifts
    assign w_hundreds = cdas_pkg::YEAR_W'({r_quot, 6'b0}) + cdas_pkg::YEAR_W'({r_quot, 5'b0})
                      + cdas_pkg::YEAR_W'({r_quot, 2'b0});
    assign w_div4     = (i_year[1:0] == 2'b00);
    assign w_div100   = (w_hundreds == i_year);

    // divisible by 400 means divisible by 100 with a quotient divisible by 4
    assign o_leap = w_div4 && (!w_div100 || (r_quot[1:0] == 2'b00));

endmodule

>>> rtl/core/cdas_step.sv
// ----------------------------------------------------------------------------
// cdas_step
// Shared month step unit: moves the working date by up to one month forward
// or back and returns the days still to go.
// ----------------------------------------------------------------------------
module cdas_step (
    input  logic                          i_back,
    input  logic [cdas_pkg::DAY_W-1:0]    i_day,
    input  logic [cdas_pkg::MONTH_W-1:0]  i_month,
    input  logic [cdas_pkg::COUNT_W-1:0]  i_count,
    input  logic                          i_leap,
    output cdas_pkg::t_step_res           o_res
);

    localparam int unsigned SUM_W = cdas_pkg::COUNT_W + 1;

    logic [cdas_pkg::MONTH_W-1:0] w_month_sel;
    logic [cdas_pkg::MONTH_W-1:0] w_prev_month;
    logic [cdas_pkg::DAY_W-1:0]   w_len;
    logic [SUM_W-1:0]             w_sum;
    logic [SUM_W-1:0]             w_used;

    // previous month wraps to december, whose length does not need the leap flag
    assign w_prev_month = (i_month == cdas_pkg::MON_JAN) ? cdas_pkg::MON_DEC
                                                         : i_month - 4'd1;
    assign w_month_sel  = i_back ? w_prev_month : i_month;
    assign w_len        = cdas_pkg::month_len(w_month_sel, i_leap);

    // forward: day plus count against month length; back: day against count
    assign w_sum  = SUM_W'(i_day) + SUM_W'(i_count);
    assign w_used = i_back ? SUM_W'(i_day) : (SUM_W'(w_len) - SUM_W'(i_day) + SUM_W'(1));

    always_comb begin
        o_res = '0;
        if (i_back) begin
            if (SUM_W'(i_day) > SUM_W'(i_count)) begin
                o_res.done  = 1'b1;
                o_res.day   = i_day - i_count[cdas_pkg::DAY_W-1:0];
                o_res.month = i_month;
                o_res.count = '0;
            end else begin
                o_res.day   = w_len;
                o_res.month = w_prev_month;
                o_res.count = i_count - w_used[cdas_pkg::COUNT_W-1:0];
                o_res.wrap  = (i_month == cdas_pkg::MON_JAN);
            end
        end else begin
            if (w_sum <= SUM_W'(w_len)) begin
                o_res.done  = 1'b1;
                o_res.day   = w_sum[cdas_pkg::DAY_W-1:0];
                o_res.month = i_month;
                o_res.count = '0;
            end else begin
                o_res.day   = cdas_pkg::DAY_W'(1);
                o_res.month = (i_month == cdas_pkg::MON_DEC) ? cdas_pkg::MON_JAN
                                                             : i_month + 4'd1;
                o_res.count = i_count - w_used[cdas_pkg::COUNT_W-1:0];
                o_res.wrap  = (i_month == cdas_pkg::MON_DEC);
            end
        end
    end

endmodule

>>> rtl/core/calendar_date_add_subtract_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_add_subtract_unit
// Holds one Gregorian date and serves load, add days, subtract days and
// compare requests, one result transfer per request.
// ----------------------------------------------------------------------------
// A request is taken only while the unit is idle. Compare skips the leap
// year test and goes straight to the result; load runs the leap year test,
// then a validity check. Add and subtract walk the date one month per cycle
// through the shared month step unit, and pause at each year boundary they
// cross for the leap year test of the new year. The largest day count is
// 4095. A finished result waits in the output register while the next
// request is already being taken.
module calendar_date_add_subtract_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // in_day[4:0], in_month[8:5], in_year[22:9],
                                       // day_count[34:23], zero fill[39:35]
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_day[4:0], out_month[8:5], out_year[22:9],
                                       // cmp_result[24:23], zero fill[31:25]
    output logic [0:0]  m_axis_tuser   // status[0]
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_LEAP = 6'b000100,
        S_LCHK = 6'b001000,
        S_STEP = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // committed date
    logic [cdas_pkg::DAY_W-1:0]   r_cur_day;
    logic [cdas_pkg::MONTH_W-1:0] r_cur_month;
    logic [cdas_pkg::YEAR_W-1:0]  r_cur_year;

    // working request
    logic [cdas_pkg::REQ_W-1:0]   r_req;
    logic [cdas_pkg::DAY_W-1:0]   r_wd;
    logic [cdas_pkg::MONTH_W-1:0] r_wm;
    logic [cdas_pkg::YEAR_W-1:0]  r_wy;
    logic [cdas_pkg::COUNT_W-1:0] r_n;
    logic                         r_leap;
    logic                         r_status;
    logic [cdas_pkg::CMP_W-1:0]   r_cmp;

    // output register
    logic                         r_ovalid;
    logic [cdas_pkg::DAY_W-1:0]   r_o_day;
    logic [cdas_pkg::MONTH_W-1:0] r_o_month;
    logic [cdas_pkg::YEAR_W-1:0]  r_o_year;
    logic                         r_o_status;
    logic [cdas_pkg::CMP_W-1:0]   r_o_cmp;

    logic [cdas_pkg::DAY_W-1:0]   w_in_day;
    logic [cdas_pkg::MONTH_W-1:0] w_in_month;
    logic [cdas_pkg::YEAR_W-1:0]  w_in_year;
    logic [cdas_pkg::COUNT_W-1:0] w_in_count;
    logic [cdas_pkg::COUNT_W-1:0] w_count_sat;
    logic [cdas_pkg::REQ_W-1:0]   w_in_req;
    logic [cdas_pkg::CMP_W-1:0]   w_cmp;
    logic                         w_in_xfer;
    logic                         w_out_free;
    logic                         w_leap;
    logic                         w_load_ok;
    logic                         w_wrap_fail;
    logic                         w_back;
    cdas_pkg::t_step_res          w_step;

    // request fields
    assign w_in_day   = s_axis_tdata[4:0];
    assign w_in_month = s_axis_tdata[8:5];
    assign w_in_year  = s_axis_tdata[22:9];
    assign w_in_count = s_axis_tdata[34:23];
    assign w_in_req   = s_axis_tuser;

    assign w_count_sat = (w_in_count > cdas_pkg::COUNT_CAP) ? cdas_pkg::COUNT_CAP : w_in_count;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_ovalid || m_axis_tready;

    // lexicographic compare of stored date against raw request date
    always_comb begin
        if ({r_cur_year, r_cur_month, r_cur_day} > {w_in_year, w_in_month, w_in_day}) begin
            w_cmp = cdas_pkg::CMP_LATER;
        end else if ({r_cur_year, r_cur_month, r_cur_day} <
                     {w_in_year, w_in_month, w_in_day}) begin
            w_cmp = cdas_pkg::CMP_EARLIER;
        end else begin
            w_cmp = cdas_pkg::CMP_EQUAL;
        end
    end

    // leap test of the working year
    cdas_leap u_leap (
        .i_clk  (i_clk),
        .i_year (r_wy),
        .o_leap (w_leap)
    );

    // shared month step unit
    assign w_back = (r_req == cdas_pkg::REQ_SUB);

    cdas_step u_step (
        .i_back  (w_back),
        .i_day   (r_wd),
        .i_month (r_wm),
        .i_count (r_n),
        .i_leap  (r_leap),
        .o_res   (w_step)
    );

    // load validation
    assign w_load_ok = (r_wm >= cdas_pkg::MON_JAN) && (r_wm <= cdas_pkg::MON_DEC) &&
                       (r_wy != '0) && (r_wy <= cdas_pkg::YEAR_LIMIT) &&
                       (r_wd != '0) && (r_wd <= cdas_pkg::month_len(r_wm, r_leap));

    // year bound on a wrapping step
    assign w_wrap_fail = w_back ? (r_wy <= cdas_pkg::YEAR_W'(1))
                                : (r_wy >= cdas_pkg::YEAR_LIMIT);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (w_in_req == cdas_pkg::REQ_CMP) ? S_DONE : S_DIV;
                end
            end
            S_DIV:  n_state = S_LEAP;
            S_LEAP: n_state = (r_req == cdas_pkg::REQ_LOAD) ? S_LCHK : S_STEP;
            S_LCHK: n_state = S_DONE;
            S_STEP: begin
                priority if (w_step.done) begin
                    n_state = S_DONE;
                end else if (w_step.wrap) begin
                    n_state = w_wrap_fail ? S_DONE : S_DIV;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_cur_day   <= cdas_pkg::RST_DAY;
            r_cur_month <= cdas_pkg::RST_MONTH;
            r_cur_year  <= cdas_pkg::RST_YEAR;
        end else begin
            r_state <= n_state;
            // result valid: load a finished result, else drop a taken one
            if (r_state == S_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_req    <= w_in_req;
                        r_n      <= w_count_sat;
                        r_status <= 1'b0;
                        r_cmp    <= (w_in_req == cdas_pkg::REQ_CMP) ? w_cmp
                                                                    : cdas_pkg::CMP_EQUAL;
                        if (w_in_req == cdas_pkg::REQ_LOAD) begin
                            r_wd <= w_in_day;
                            r_wm <= w_in_month;
                            r_wy <= w_in_year;
                        end else begin
                            r_wd <= r_cur_day;
                            r_wm <= r_cur_month;
                            r_wy <= r_cur_year;
                        end
                    end
                end
                S_DIV: begin
                end
                S_LEAP: begin
                    r_leap <= w_leap;
                end
                S_LCHK: begin
                    if (w_load_ok) begin
                        r_cur_day   <= r_wd;
                        r_cur_month <= r_wm;
                        r_cur_year  <= r_wy;
                    end else begin
                        r_status <= 1'b1;
                    end
                end
                S_STEP: begin
                    priority if (w_step.done) begin
                        r_cur_day   <= w_step.day;
                        r_cur_month <= w_step.month;
                        r_cur_year  <= r_wy;
                    end else if (w_step.wrap && w_wrap_fail) begin
                        r_status <= 1'b1;
                    end else begin
                        r_wd <= w_step.day;
                        r_wm <= w_step.month;
                        r_n  <= w_step.count;
                        if (w_step.wrap) begin
                            r_wy <= w_back ? (r_wy - cdas_pkg::YEAR_W'(1))
                                           : (r_wy + cdas_pkg::YEAR_W'(1));
                        end
                    end
                end
                S_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_o_day    <= r_cur_day;
            r_o_month  <= r_cur_month;
            r_o_year   <= r_cur_year;
            r_o_status <= r_status;
            r_o_cmp    <= r_cmp;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'b0, r_o_cmp, r_o_year, r_o_month, r_o_day};
    assign m_axis_tuser  = r_o_status;

    // stored date stays in range: month 1 to 12, nonzero day, year 1 to the year limit
    a_cur_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_month >= cdas_pkg::MON_JAN) && (r_cur_month <= cdas_pkg::MON_DEC) &&
        (r_cur_day != '0) && (r_cur_year != '0) && (r_cur_year <= cdas_pkg::YEAR_LIMIT))
        else $error("stored date out of range");

    // the stored date only moves when a load or a step commits
    a_cur_commit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable({r_cur_year, r_cur_month, r_cur_day}) && $past(i_rst_n) |->
        ($past(r_state) == S_LCHK) || ($past(r_state) == S_STEP))
        else $error("stored date changed outside a commit");

    // a failed request never carries a compare code
    a_status_cmp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[24:23] == cdas_pkg::CMP_EQUAL))
        else $error("error status together with compare result");

    // the remaining day count never grows while stepping
    a_count_falls : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) && $past(r_state == S_STEP) && $past(i_rst_n) |->
        r_n <= $past(r_n))
        else $error("day count grew during stepping");

endmodule
